[rtl/delta_list_task_scheduler_core_macros.svh]
// assertion macros for the delta list scheduler
`ifndef DELTA_LIST_TASK_SCHEDULER_CORE_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DLTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DLTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/dlts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlts_pkg
// types and constants shared by the delta list scheduler
// ----------------------------------------------------------------------------
package dlts_pkg;
  localparam int MaxTasksDef = 16;
  localparam int TickMsDef   = 10;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_DISP = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  task_id;
    logic [31:0] first_ms;
    logic [31:0] period_ms;
    logic        one_shot;
    logic [3:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    logic       ran_valid;
    logic [7:0] ran_task_id;
    logic       add_rejected;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] delta;
    logic [31:0] period;
    logic [7:0]  run_count;
    logic        single;
  } slot_t;

  // request from the control sequencer to the divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } div_req_t;
endpackage
`default_nettype wire

[rtl/delta_list_task_scheduler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_core
// delta sorted timer queue held in a slot memory
// ----------------------------------------------------------------------------
// Input words carry a mode (tick, add, delete, dispatch) and arguments; each
// accepted word gives exactly one output word (ran flag, task id, reject).
// The slot table lives in one memory with a registered read; every
// operation runs as a sequence that reads, modifies and writes back entries
// one at a time, the used count being held in a register.
// An add runs two reciprocal divides, then walks the list and shifts the
// later slots up one at a time; a delete shifts the later slots down; a
// one-shot dispatch is a removal, a periodic one a removal then a re-insert.
// With the one memory and the slot by slot walk, a word takes longer the
// more slots are in use.
// One word is worked on at a time; in_stall is high while busy. A finished
// result moves into the output register; if that still holds a word the
// receiver has not taken, the sequencer waits and the input stays stalled.
// Reset empties the table at once through the count register; entries
// beyond the count are never used.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_core #(
  parameter int MAX_TASKS = dlts_pkg::MaxTasksDef,
  parameter int TICK_MS   = dlts_pkg::TickMsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dlts_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dlts_pkg::out_word_t      out_data
);
  import dlts_pkg::*;
  `include "delta_list_task_scheduler_core_macros.svh"

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_TASKS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_DIV2  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_SHRD  = 4'd6;
  localparam logic [3:0] S_SHWR  = 4'd7;
  localparam logic [3:0] S_RMRD  = 4'd8;
  localparam logic [3:0] S_RMWR  = 4'd9;
  localparam logic [3:0] S_DISP  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  slot_t mem [MAX_TASKS];
  slot_t rd_q;
  logic  we;
  logic [AW-1:0] wa, ra;
  slot_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] at_r, at_nxt;
  in_word_t      req_r, req_nxt;
  logic [31:0]   dt_r, dt_nxt, pt_r, pt_nxt;
  logic          reins_r, reins_nxt;
  logic          ov_r, ov_nxt;
  out_word_t     od_r, od_nxt;
  out_word_t     res_r, res_nxt;
  div_req_t      dreq;
  logic          ddone;
  logic [31:0]   dq;
  slot_t         ins;

  dlts_div #(.TICK_MS(TICK_MS)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq)
  );

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    ins.task_id   = req_r.task_id;
    ins.delta     = dt_r;
    ins.period    = pt_r;
    ins.run_count = 8'd0;
    ins.single    = req_r.one_shot;
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; idx_nxt = idx_r; at_nxt = at_r;
    req_nxt = req_r; dt_nxt = dt_r; pt_nxt = pt_r; reins_nxt = reins_r;
    ov_nxt = ov_r; od_nxt = od_r; res_nxt = res_r;
    we = 1'b0; wa = '0; wd = rd_q; ra = '0;
    dreq.start = 1'b0; dreq.dividend = req_r.first_ms;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          req_nxt = in_data;
          res_nxt = '0;
          reins_nxt = 1'b0;
          unique case (in_data.mode)
            MODE_TICK: st_nxt = (cnt_r != '0) ? S_TICK : S_OUT;
            MODE_ADD: begin
              if (cnt_r == Full) begin
                res_nxt.add_rejected = 1'b1;
                st_nxt = S_OUT;
              end else begin
                dreq.start = 1'b1;
                dreq.dividend = in_data.first_ms;
                st_nxt = S_DIV1;
              end
            end
            MODE_DEL: begin
              // slots at or past the count are unused, deleting them is a no-op
              if (32'(in_data.slot_index) < 32'(cnt_r)) begin
                idx_nxt = CW'(in_data.slot_index);
                st_nxt = S_RMRD;
              end else st_nxt = S_OUT;
            end
            MODE_DISP: st_nxt = (cnt_r != '0) ? S_DISP : S_OUT;
            default: st_nxt = S_OUT;
          endcase
          ra = '0;
        end
      end
      S_TICK: begin
        we = 1'b1; wa = '0; wd = rd_q;
        if (rd_q.delta == '0) wd.run_count = rd_q.run_count + 8'd1;
        else wd.delta = rd_q.delta - 32'd1;
        st_nxt = S_OUT;
      end
      S_DIV1: begin
        if (ddone) begin
          dt_nxt = dq;
          dreq.start = 1'b1;
          dreq.dividend = req_r.period_ms;
          st_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (ddone) begin
          pt_nxt = dq;
          idx_nxt = '0;
          ra = '0;
          st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // rd_q holds slot idx_r
        if (idx_r < cnt_r && rd_q.delta <= dt_r) begin
          dt_nxt = dt_r - rd_q.delta;
          idx_nxt = idx_r + CW'(1);
          ra = AW'(idx_r + CW'(1));
          st_nxt = S_WCHK;
        end else begin
          at_nxt = idx_r;
          if (idx_r < cnt_r) begin
            we = 1'b1; wa = AW'(idx_r); wd = rd_q;
            wd.delta = rd_q.delta - dt_r;
          end
          idx_nxt = cnt_r;
          st_nxt = S_SHRD;
        end
      end
      S_WCHK: begin
        ra = AW'(idx_r);
        st_nxt = S_WALK;
      end
      S_SHRD: begin
        if (idx_r == at_r) begin
          we = 1'b1; wa = AW'(at_r); wd = ins;
          cnt_nxt = cnt_r + CW'(1);
          st_nxt = S_OUT;
        end else begin
          ra = AW'(idx_r - CW'(1));
          st_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; wa = AW'(idx_r); wd = rd_q;
        idx_nxt = idx_r - CW'(1);
        st_nxt = S_SHRD;
      end
      S_RMRD: begin
        if (idx_r + CW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          if (reins_r) begin
            idx_nxt = '0; ra = '0; st_nxt = S_WCHK;
          end else st_nxt = S_OUT;
        end else begin
          ra = AW'(idx_r + CW'(1));
          st_nxt = S_RMWR;
        end
      end
      S_RMWR: begin
        we = 1'b1; wa = AW'(idx_r); wd = rd_q;
        idx_nxt = idx_r + CW'(1);
        st_nxt = S_RMRD;
      end
      S_DISP: begin
        if (rd_q.run_count != 8'd0) begin
          res_nxt.ran_valid = 1'b1;
          res_nxt.ran_task_id = rd_q.task_id;
          req_nxt.task_id = rd_q.task_id;
          req_nxt.one_shot = rd_q.single;
          dt_nxt = rd_q.period;
          pt_nxt = rd_q.period;
          reins_nxt = !rd_q.single;
          idx_nxt = '0;
          st_nxt = S_RMRD;
        end else st_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here while the output register still holds an untaken word
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = res_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    idx_r <= idx_nxt; at_r <= at_nxt; req_r <= req_nxt;
    dt_r <= dt_nxt; pt_r <= pt_nxt; reins_r <= reins_nxt; od_r <= od_nxt;
    res_r <= res_nxt;
  end

  `DLTS_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= Full)
  `DLTS_ASSERT_IMPL(a_state_ok, clk, rst_n, 1'b1, st_r <= S_OUT)
  `DLTS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, st_r != S_IDLE)
  `DLTS_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_r && out_stall, ov_r && $stable(od_r))
  `DLTS_ASSERT_IMPL(a_rej_full, clk, rst_n, st_r == S_OUT && res_r.add_rejected, cnt_r == Full)
endmodule
`default_nettype wire

[rtl/dlts_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlts_div
// division by a constant through a reciprocal multiply, result registered
// ----------------------------------------------------------------------------
module dlts_div #(
  parameter int TICK_MS = dlts_pkg::TickMsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dlts_pkg::div_req_t req,
  output logic                    done,
  output logic [31:0]             quot
);
  // magic = floor(2^(32+L) / TICK_MS) + 1 always has bit 32 set,
  // so x * magic = x * low word + (x << 32)
  localparam int          L       = $clog2(TICK_MS);
  localparam logic [63:0] Magic   = ((64'd1 << (32 + L)) / 64'(TICK_MS)) + 64'd1;
  localparam logic [31:0] MagicLo = Magic[31:0];

  logic [31:0] x_r, x_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        v_r, v_nxt;
  logic [64:0] sum;

  always_comb begin
    x_nxt    = x_r;
    prod_nxt = prod_r;
    v_nxt    = req.start;
    if (req.start) begin
      x_nxt    = req.dividend;
      prod_nxt = 64'(req.dividend) * 64'(MagicLo);
    end
    sum = {1'b0, prod_r} + {1'b0, x_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
  end

  assign done = v_r;
  assign quot = 32'(sum >> (32 + L));
endmodule
`default_nettype wire

[tb/delta_list_task_scheduler_core_tb.sv]
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_core_tb
// self-checking bench: a shadow delta list predicts every output word
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_core_tb;
  import dlts_pkg::*;

  localparam int NumSlots  = MaxTasksDef;
  localparam int TickMs    = TickMsDef;
  localparam int IdleLimit = 6000;

  typedef struct packed {
    logic     sync;  // wait for the due output words to drain before this word
    in_word_t w;
  } pend_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  pend_t     pending_words[$];
  out_word_t due_words[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        accepted_in = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        quiet = 1'b0;

  // shadow of the slot table
  bit    shadow_used[NumSlots];
  slot_t shadow_slot[NumSlots];

  delta_list_task_scheduler_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void shadow_remove(int idx);
    for (int i = idx + 1; i < NumSlots; i++) begin
      shadow_used[i-1] = shadow_used[i];
      shadow_slot[i-1] = shadow_slot[i];
    end
    shadow_used[NumSlots-1] = 1'b0;
    shadow_slot[NumSlots-1] = '0;
  endfunction

  function automatic bit shadow_insert(logic [7:0] id, logic [31:0] dt,
                                       logic [31:0] pt, logic sgl);
    int count;
    int at;
    count = 0;
    at = 0;
    while (count < NumSlots && shadow_used[count]) count++;
    if (count >= NumSlots) return 1'b0;
    for (int i = 0; i <= count; i++) begin
      if (shadow_used[i] && shadow_slot[i].delta <= dt) begin
        dt = dt - shadow_slot[i].delta;
      end else begin
        at = i;
        if (shadow_used[i]) shadow_slot[i].delta = shadow_slot[i].delta - dt;
        break;
      end
    end
    for (int i = count; i > at; i--) begin
      shadow_used[i] = shadow_used[i-1];
      shadow_slot[i] = shadow_slot[i-1];
    end
    shadow_used[at] = 1'b1;
    shadow_slot[at].task_id = id;
    shadow_slot[at].delta = dt;
    shadow_slot[at].period = pt;
    shadow_slot[at].run_count = 8'd0;
    shadow_slot[at].single = sgl;
    return 1'b1;
  endfunction

  function automatic out_word_t schedule_step(in_word_t w);
    out_word_t r;
    slot_t     hd;
    r = '0;
    case (w.mode)
      MODE_TICK: begin
        if (shadow_used[0]) begin
          if (shadow_slot[0].delta == 0)
            shadow_slot[0].run_count = shadow_slot[0].run_count + 8'd1;
          else
            shadow_slot[0].delta = shadow_slot[0].delta - 1;
        end
      end
      MODE_ADD: begin
        if (!shadow_insert(w.task_id, w.first_ms / TickMs, w.period_ms / TickMs,
                           w.one_shot))
          r.add_rejected = 1'b1;
      end
      MODE_DEL: begin
        shadow_remove(int'(w.slot_index));
      end
      default: begin
        if (shadow_used[0] && shadow_slot[0].run_count > 0) begin
          hd = shadow_slot[0];
          r.ran_valid = 1'b1;
          r.ran_task_id = hd.task_id;
          shadow_remove(0);
          if (!hd.single) void'(shadow_insert(hd.task_id, hd.period, hd.period, 1'b0));
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_ms();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(0, 60);
    if (k < 90) return $urandom_range(0, 5000);
    return $urandom();
  endfunction

  function automatic in_word_t make_word(logic [1:0] m);
    in_word_t w;
    w.mode = m;
    w.task_id = $urandom_range(0, 255);
    w.first_ms = pick_ms();
    w.period_ms = pick_ms();
    w.one_shot = $urandom_range(0, 3) == 0;
    w.slot_index = $urandom_range(0, 15);
    return w;
  endfunction

  function automatic pend_t as_pend(in_word_t w, bit s);
    pend_t p;
    p.sync = s;
    p.w = w;
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    pend_t p;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due_words.push_back(schedule_step(in_data));
        accepted_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].sync ||
                      (!in_valid && due_words.size() == 0))) begin
          p = pending_words.pop_front();
          in_data <= p.w;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          e = due_words.pop_front();
          if (out_data.ran_valid !== e.ran_valid) begin
            $error("ran_valid exp %0d got %0d", e.ran_valid, out_data.ran_valid);
            errors++;
          end
          if (out_data.ran_task_id !== e.ran_task_id) begin
            $error("ran_task_id exp %0d got %0d", e.ran_task_id, out_data.ran_task_id);
            errors++;
          end
          if (out_data.add_rejected !== e.add_rejected) begin
            $error("add_rejected exp %0d got %0d", e.add_rejected, out_data.add_rejected);
            errors++;
          end
        end
      end
      if (!hold_done && accepted_in >= 400) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= hold_left > 1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= recv_gap > 1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("delta_list_task_scheduler_core_tb: errors");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int       wa;
    int       wt;
    int       wd;
    int       k;
    for (int i = 0; i < NumSlots; i++) begin
      shadow_used[i] = 1'b0;
      shadow_slot[i] = '0;
    end
    // directed: empty table, extremes, fill to full, dispatch and delete
    w = make_word(MODE_TICK); pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_DISP); pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_DEL); w.slot_index = 4'hF; pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_ADD); w.task_id = 8'hFF; w.first_ms = '1; w.period_ms = '1;
    w.one_shot = 1'b1; pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_ADD); w.task_id = 8'h00; w.first_ms = '0; w.period_ms = '0;
    w.one_shot = 1'b0; pending_words.push_back(as_pend(w, 0));
    for (int i = 0; i < 15; i++) begin
      w = make_word(MODE_ADD); w.first_ms = 10 * i + 5;
      pending_words.push_back(as_pend(w, 0));
    end
    w = make_word(MODE_TICK); pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_TICK); pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_DISP); pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_DEL); w.slot_index = 4'h0; pending_words.push_back(as_pend(w, 0));
    w = make_word(MODE_DEL); w.slot_index = 4'h7; pending_words.push_back(as_pend(w, 0));
    // random segments with varying mix
    for (int seg = 0; seg < 68; seg++) begin
      wa = $urandom_range(1, 6);
      wt = $urandom_range(1, 8);
      wd = $urandom_range(1, 5);
      for (int i = 0; i < 20; i++) begin
        k = $urandom_range(0, wa + wt + wd + 1);
        if (k < wa) w = make_word(MODE_ADD);
        else if (k < wa + wt) w = make_word(MODE_TICK);
        else if (k < wa + wt + wd) w = make_word(MODE_DISP);
        else w = make_word(MODE_DEL);
        pending_words.push_back(as_pend(w, seg == 40 && i == 0));
      end
      if (seg == 20) begin
        // a task due at once, then ticks past 256 runs: a ready head's count wraps
        w = make_word(MODE_ADD); w.first_ms = 0; pending_words.push_back(as_pend(w, 0));
        for (int i = 0; i < 262; i++) begin
          w = make_word(MODE_TICK); pending_words.push_back(as_pend(w, 0));
        end
        w = make_word(MODE_DISP); pending_words.push_back(as_pend(w, 0));
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() < 150);
    quiet = 1'b1;
    wait (pending_words.size() == 0 && !in_valid && due_words.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("delta_list_task_scheduler_core_tb: clean");
    end else begin
      $display("delta_list_task_scheduler_core_tb: errors");
    end
    $finish;
  end
endmodule
